FILE: hdl/pcbod_pkg.sv
// pcbod_pkg: shared types and constants for the box obstacle detector
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcbod_pkg;

  localparam int COORD_BITS     = 16;
  localparam int COUNT_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0]        HIT_MAX   = {COUNT_BITS{1'b1}};

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_MIN_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_MAX_X      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_HALF_WIDTH = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_MIN_Z      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_MAX_Z      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_HITS        = 3'd5;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic                         finite;
    logic                         last_point;
  } in_item_t;

  typedef struct packed {
    logic                         obstacle;
    logic [COUNT_BITS-1:0]        hit_count;
    logic signed [COORD_BITS-1:0] nearest_x;
    logic                         zone_bad;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] zone_min_x;
    logic signed [COORD_BITS-1:0] zone_max_x;
    logic signed [COORD_BITS-1:0] zone_half_width;
    logic signed [COORD_BITS-1:0] zone_min_z;
    logic signed [COORD_BITS-1:0] zone_max_z;
    logic [COUNT_BITS-1:0]        min_hits;
  } zone_cfg_t;

  // classified point as it travels from front to back
  typedef struct packed {
    logic                         hit;
    logic                         zone_bad;
    logic                         last;
    logic signed [COORD_BITS-1:0] x;
  } work_item_t;

endpackage : pcbod_pkg

`default_nettype wire

FILE: hdl/pcbod_front.sv
// pcbod_front: classifies each accepted point against the zone box
// depends on pcbod_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcbod_front
  import pcbod_pkg::*;
(
  input  wire in_item_t   item,
  input  wire zone_cfg_t  cfg,
  output work_item_t      work
);

  logic signed [COORD_BITS:0] py_ext;
  logic signed [COORD_BITS:0] abs_y;
  logic signed [COORD_BITS:0] hw_ext;
  logic                       in_x;
  logic                       in_y;
  logic                       in_z;
  logic                       zone_ok;

  always_comb begin
    // |y| one bit wider so the most negative y stays exact
    py_ext = {item.py[COORD_BITS-1], item.py};
    abs_y  = item.py[COORD_BITS-1] ? -py_ext : py_ext;
    hw_ext = {cfg.zone_half_width[COORD_BITS-1], cfg.zone_half_width};

    in_x = (item.px >= cfg.zone_min_x) && (item.px <= cfg.zone_max_x);
    in_y = (abs_y <= hw_ext);
    in_z = (item.pz >= cfg.zone_min_z) && (item.pz <= cfg.zone_max_z);

    zone_ok = !cfg.zone_min_x[COORD_BITS-1]
           && (cfg.zone_min_x < cfg.zone_max_x)
           && !cfg.zone_half_width[COORD_BITS-1]
           && (cfg.zone_half_width != '0)
           && (cfg.zone_min_z < cfg.zone_max_z)
           && (cfg.min_hits != '0);

    work.hit      = item.finite && in_x && in_y && in_z;
    work.zone_bad = !zone_ok;
    work.last     = item.last_point;
    work.x        = item.px;
  end

endmodule : pcbod_front

`default_nettype wire

FILE: hdl/pcbod_queue.sv
// pcbod_queue: short fifo of classified points between front and back
// depends on pcbod_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcbod_queue
  import pcbod_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         push,
  input  wire         work_item_t push_item,
  output logic        full,
  input  wire         pop,
  output logic        head_valid,
  output work_item_t  head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_item_t         data_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    full       = (count_r == CNT_W'(DEPTH));
    head_valid = (count_r != '0);
    head_item  = data_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && head_valid;

    wr_ptr_nxt = wr_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    rd_ptr_nxt = rd_ptr_r;
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end

    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : pcbod_queue

`default_nettype wire

FILE: hdl/pcbod_back.sv
// pcbod_back: accumulates hit count and nearest x, forms the frame result
// depends on pcbod_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcbod_back
  import pcbod_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   head_valid,
  input  wire work_item_t       head_item,
  input  wire [COUNT_BITS-1:0]  min_hits,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_stall,
  output out_item_t             out_item
);

  logic [COUNT_BITS-1:0]        hits_r;
  logic [COUNT_BITS-1:0]        hits_nxt;
  logic signed [COORD_BITS-1:0] closest_r;
  logic signed [COORD_BITS-1:0] closest_nxt;
  logic [COUNT_BITS-1:0]        hits_upd;
  logic signed [COORD_BITS-1:0] closest_upd;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  out_item_t                    out_item_r;
  out_item_t                    out_item_nxt;

  always_comb begin
    // only a frame end needs room in the output register
    pop = head_valid && (!head_item.last || !out_valid_r || !out_stall);

    hits_upd    = hits_r;
    closest_upd = closest_r;
    if (head_item.hit) begin
      if (hits_r != HIT_MAX) begin
        hits_upd = hits_r + COUNT_BITS'(1);
      end
      if (head_item.x < closest_r) begin
        closest_upd = head_item.x;
      end
    end

    hits_nxt      = hits_r;
    closest_nxt   = closest_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (pop) begin
      if (head_item.last) begin
        hits_nxt      = '0;
        closest_nxt   = COORD_MAX;
        out_valid_nxt = 1'b1;
        if (head_item.zone_bad) begin
          out_item_nxt.obstacle  = 1'b1;
          out_item_nxt.hit_count = '0;
          out_item_nxt.nearest_x = COORD_MAX;
          out_item_nxt.zone_bad  = 1'b1;
        end else begin
          out_item_nxt.obstacle  = (hits_upd >= min_hits);
          out_item_nxt.hit_count = hits_upd;
          out_item_nxt.nearest_x = closest_upd;
          out_item_nxt.zone_bad  = 1'b0;
        end
      end else begin
        hits_nxt    = hits_upd;
        closest_nxt = closest_upd;
      end
    end

    out_valid = out_valid_r;
    out_item  = out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      closest_r   <= COORD_MAX;
      out_valid_r <= 1'b0;
    end else begin
      hits_r      <= hits_nxt;
      closest_r   <= closest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule : pcbod_back

`default_nettype wire

FILE: hdl/point_cloud_box_obstacle_detect.sv
// point_cloud_box_obstacle_detect: counts frame points inside a box zone
// a frame's result is registered in the back end once its last point leaves the queue
// throughput: one point per cycle while in_stall is low, limited by the back-end accumulate step
// the fifo of QUEUE_DEPTH entries absorbs output stalls before in_stall rises
// reset: synchronous active-low rst_n restores zone registers and clears counters
// depends on pcbod_pkg, pcbod_front, pcbod_queue, pcbod_back
`timescale 1ns / 1ps
`default_nettype none

module point_cloud_box_obstacle_detect
  import pcbod_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire                       out_stall,
  output out_item_t                 out_item,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [CFG_DATA_BITS-1:0]   cfg_data
);

  zone_cfg_t   cfg_r;
  zone_cfg_t   cfg_nxt;
  work_item_t  front_work;
  work_item_t  head_item;
  logic        head_valid;
  logic        q_full;
  logic        pop;
  logic        in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_take   = in_valid && !q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ZONE_MIN_X:      cfg_nxt.zone_min_x      = cfg_data;
        REG_ZONE_MAX_X:      cfg_nxt.zone_max_x      = cfg_data;
        REG_ZONE_HALF_WIDTH: cfg_nxt.zone_half_width = cfg_data;
        REG_ZONE_MIN_Z:      cfg_nxt.zone_min_z      = cfg_data;
        REG_ZONE_MAX_Z:      cfg_nxt.zone_max_z      = cfg_data;
        REG_MIN_HITS:        cfg_nxt.min_hits        = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone_min_x      <= 16'sd0;
      cfg_r.zone_max_x      <= 16'sd1000;
      cfg_r.zone_half_width <= 16'sd300;
      cfg_r.zone_min_z      <= 16'sd0;
      cfg_r.zone_max_z      <= 16'sd1000;
      cfg_r.min_hits        <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pcbod_front u_front (
    .item (in_item),
    .cfg  (cfg_r),
    .work (front_work)
  );

  pcbod_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_take),
    .push_item  (front_work),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  pcbod_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .min_hits   (cfg_r.min_hits),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

`ifndef ASSERT_OFF
  // a new result only appears after a frame end left the queue
  a_result_from_last : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop && head_item.last))
    else $error("result without frame end");

  // a bad zone reports a fixed result
  a_bad_zone_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.zone_bad) |->
      (out_item.obstacle && (out_item.hit_count == '0) && (out_item.nearest_x == COORD_MAX)))
    else $error("bad zone result malformed");

  // obstacle on a good zone follows the threshold
  a_obstacle_threshold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.zone_bad) |->
      (out_item.obstacle == (out_item.hit_count >= cfg_r.min_hits)))
    else $error("obstacle flag disagrees with count");

  // an empty good zone never reports a nearest x below the top value
  a_empty_nearest : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.zone_bad && (out_item.hit_count == '0)) |->
      (out_item.nearest_x == COORD_MAX))
    else $error("nearest x set with no hits");
`endif

endmodule : point_cloud_box_obstacle_detect

`default_nettype wire

FILE: verif/point_cloud_box_obstacle_detect_test.sv
// point_cloud_box_obstacle_detect_test: self-checking bench for the box obstacle detector
// drives point frames and zone register writes, predicts each frame report, compares field by field
// depends on pcbod_pkg and point_cloud_box_obstacle_detect
`timescale 1ns / 1ps

module point_cloud_box_obstacle_detect_test;
  import pcbod_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 800;
  localparam int CALM_FROM     = 650;
  localparam int LONG_HOLD     = 300;

  typedef enum logic {ROW_POINT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  val;
    in_item_t                  pt;
    bit                        known;
    out_item_t                 want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  in_item_t                  in_item = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_item_t                 out_item;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // predictor state: zone registers and the running frame tally
  zone_cfg_t                    zone_now = '{16'sd0, 16'sd1000, 16'sd300, 16'sd0, 16'sd1000, 16'd1};
  logic [COUNT_BITS-1:0]        frame_hits = '0;
  logic signed [COORD_BITS-1:0] frame_nearest = COORD_MAX;

  out_item_t frame_reports_due[$];
  stim_row_t plan[$];
  int        mismatches = 0;
  int        points_sent = 0;
  int        cycle_count = 0;
  int        hold_off_left = 0;
  int        stall_burst = 0;
  bit        idle_on = 1'b1;

  point_cloud_box_obstacle_detect i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side stall: one long hold-off on request, otherwise random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_burst = 0;
    end else if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else if (stall_burst > 0) begin
      out_stall <= 1'b1;
      stall_burst--;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_burst = $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic compare_field(input string fname, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, fname, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (frame_reports_due.size() == 0) begin
        $display("%0t: unexpected report, expected none got %h", $time, out_item);
        mismatches++;
      end else begin
        want = frame_reports_due.pop_front();
        compare_field("obstacle", 32'(want.obstacle), 32'(out_item.obstacle));
        compare_field("hit_count", 32'(want.hit_count), 32'(out_item.hit_count));
        compare_field("nearest_x", 32'(want.nearest_x), 32'(out_item.nearest_x));
        compare_field("zone_bad", 32'(want.zone_bad), 32'(out_item.zone_bad));
      end
    end
  end

  function automatic void set_zone_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                       input logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_ZONE_MIN_X:      zone_now.zone_min_x = val;
      REG_ZONE_MAX_X:      zone_now.zone_max_x = val;
      REG_ZONE_HALF_WIDTH: zone_now.zone_half_width = val;
      REG_ZONE_MIN_Z:      zone_now.zone_min_z = val;
      REG_ZONE_MAX_Z:      zone_now.zone_max_z = val;
      REG_MIN_HITS:        zone_now.min_hits = val;
      default: ;
    endcase
  endfunction

  // tallies one point; returns 1 with the frame report when the point closes a frame
  function automatic bit count_point(input in_item_t p, output out_item_t r);
    int ay;
    bit zone_valid;
    ay = (int'(p.py) < 0) ? -int'(p.py) : int'(p.py);
    r = '0;
    if (p.finite &&
        int'(p.px) >= int'(zone_now.zone_min_x) && int'(p.px) <= int'(zone_now.zone_max_x) &&
        ay <= int'(zone_now.zone_half_width) &&
        int'(p.pz) >= int'(zone_now.zone_min_z) && int'(p.pz) <= int'(zone_now.zone_max_z)) begin
      if (frame_hits != HIT_MAX) frame_hits++;
      if (int'(p.px) < int'(frame_nearest)) frame_nearest = p.px;
    end
    if (!p.last_point) return 1'b0;
    zone_valid = int'(zone_now.zone_min_x) >= 0 &&
                 int'(zone_now.zone_min_x) < int'(zone_now.zone_max_x) &&
                 int'(zone_now.zone_half_width) > 0 &&
                 int'(zone_now.zone_min_z) < int'(zone_now.zone_max_z) &&
                 zone_now.min_hits != 0;
    if (!zone_valid) begin
      r.obstacle  = 1'b1;
      r.hit_count = '0;
      r.nearest_x = COORD_MAX;
      r.zone_bad  = 1'b1;
    end else begin
      r.obstacle  = frame_hits >= zone_now.min_hits;
      r.hit_count = frame_hits;
      r.nearest_x = frame_nearest;
      r.zone_bad  = 1'b0;
    end
    frame_hits = '0;
    frame_nearest = COORD_MAX;
    return 1'b1;
  endfunction

  function automatic in_item_t pt(input int x, input int y, input int z, input bit fin,
                                  input bit last);
    in_item_t p;
    p.px = x[COORD_BITS-1:0];
    p.py = y[COORD_BITS-1:0];
    p.pz = z[COORD_BITS-1:0];
    p.finite = fin;
    p.last_point = last;
    return p;
  endfunction

  function automatic out_item_t res(input bit obst, input int cnt, input int near_x,
                                    input bit bad);
    out_item_t r;
    r.obstacle = obst;
    r.hit_count = cnt[COUNT_BITS-1:0];
    r.nearest_x = near_x[COORD_BITS-1:0];
    r.zone_bad = bad;
    return r;
  endfunction

  function automatic void plan_point(input in_item_t p);
    plan.push_back('{ROW_POINT, REG_ZONE_MIN_X, '0, p, 1'b0, '0});
  endfunction

  function automatic void plan_known(input in_item_t p, input out_item_t r);
    plan.push_back('{ROW_POINT, REG_ZONE_MIN_X, '0, p, 1'b1, r});
  endfunction

  function automatic void plan_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
    plan.push_back('{ROW_REG, idx, val[CFG_DATA_BITS-1:0], '0, 1'b0, '0});
  endfunction

  // values clustered on and around [lo, hi], with some anywhere in range
  function automatic logic signed [COORD_BITS-1:0] coord_near(input int lo, input int hi);
    int v;
    int t;
    logic [COORD_BITS-1:0] raw;
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    case ($urandom_range(0, 9))
      0: v = lo;
      1: v = hi;
      2: begin
        raw = COORD_BITS'($urandom);
        v = int'($signed(raw));
      end
      default: v = lo - 3 + int'($urandom_range(0, hi - lo + 6));
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic in_item_t random_point(input bit last);
    in_item_t p;
    p.px = coord_near(zone_now.zone_min_x, zone_now.zone_max_x);
    p.py = coord_near(-int'(zone_now.zone_half_width), zone_now.zone_half_width);
    p.pz = coord_near(zone_now.zone_min_z, zone_now.zone_max_z);
    p.finite = $urandom_range(0, 9) != 0;
    p.last_point = last;
    return p;
  endfunction

  task automatic offer_point(input in_item_t p, input bit known, input out_item_t want);
    out_item_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (count_point(p, r)) frame_reports_due.push_back(known ? want : r);
    points_sent++;
  endtask

  // hold the input, let every due report arrive and the pipeline empty
  task automatic await_idle();
    in_valid <= 1'b0;
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    await_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    set_zone_reg(idx, val);
  endtask

  // flavor 0: anything, 1: a valid zone with one validation rule broken, else a plain valid zone
  task automatic random_zone(input int flavor);
    int nx, fx, hw, lz, uz, mh;
    logic [CFG_INDEX_BITS-1:0] broken;
    nx = $urandom_range(0, 2000);
    fx = nx + $urandom_range(1, 3000);
    hw = $urandom_range(1, 1500);
    lz = $urandom_range(0, 2000) - 1000;
    uz = lz + $urandom_range(1, 2000);
    mh = $urandom_range(1, 4);
    if (flavor == 0) begin
      nx = $urandom;
      fx = $urandom;
      hw = $urandom;
      lz = $urandom;
      uz = $urandom;
      mh = $urandom;
    end else if (flavor == 1) begin
      broken = CFG_INDEX_BITS'($urandom_range(0, 5));
      case (broken)
        REG_ZONE_MIN_X:      nx = -1 - int'($urandom_range(0, 100));
        REG_ZONE_MAX_X:      fx = nx;
        REG_ZONE_HALF_WIDTH: hw = -int'($urandom_range(0, 100));
        REG_ZONE_MIN_Z:      lz = uz;
        REG_ZONE_MAX_Z:      uz = lz - 1;
        default:             mh = 0;
      endcase
    end
    write_reg(REG_ZONE_MIN_X, nx[CFG_DATA_BITS-1:0]);
    write_reg(REG_ZONE_MAX_X, fx[CFG_DATA_BITS-1:0]);
    write_reg(REG_ZONE_HALF_WIDTH, hw[CFG_DATA_BITS-1:0]);
    write_reg(REG_ZONE_MIN_Z, lz[CFG_DATA_BITS-1:0]);
    write_reg(REG_ZONE_MAX_Z, uz[CFG_DATA_BITS-1:0]);
    write_reg(REG_MIN_HITS, mh[CFG_DATA_BITS-1:0]);
  endtask

  initial begin
    int len;
    bit paused_once;
    paused_once = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset zone: x and z in [0,1000], |y| up to 300, one hit needed
    plan_known(pt(500, 0, 500, 1, 1), res(1, 1, 500, 0));
    plan_point(pt(0, 0, 0, 1, 0));
    plan_point(pt(1000, 300, 1000, 1, 0));
    plan_point(pt(1000, -300, 1000, 1, 0));
    plan_point(pt(1001, 0, 500, 1, 0));
    plan_point(pt(-1, 0, 500, 1, 0));
    plan_point(pt(100, 301, 500, 1, 0));
    plan_point(pt(100, 0, 1001, 1, 0));
    plan_point(pt(5, 0, 5, 0, 0));
    plan_point(pt(2000, 0, 0, 1, 1));
    plan_known(pt(-32768, -32768, -32768, 1, 1), res(0, 0, 32767, 0));
    plan_known(pt(32767, 32767, 32767, 0, 1), res(0, 0, 32767, 0));
    // widest zone; |y| of -32768 still falls outside
    plan_reg(REG_ZONE_MAX_X, 32767);
    plan_reg(REG_ZONE_HALF_WIDTH, 32767);
    plan_reg(REG_ZONE_MIN_Z, -32768);
    plan_reg(REG_ZONE_MAX_Z, 32767);
    plan_reg(REG_MIN_HITS, 65535);
    plan_point(pt(0, -32768, -32768, 1, 0));
    plan_point(pt(32767, -32767, 32767, 1, 1));
    // each validation rule broken in turn
    plan_reg(REG_MIN_HITS, 0);
    plan_known(pt(10, 0, 10, 1, 1), res(1, 0, 32767, 1));
    plan_reg(REG_MIN_HITS, 2);
    plan_reg(REG_ZONE_MIN_X, -1);
    plan_known(pt(10, 0, 10, 1, 1), res(1, 0, 32767, 1));
    plan_reg(REG_ZONE_MIN_X, 500);
    plan_reg(REG_ZONE_MAX_X, 500);
    plan_known(pt(500, 0, 10, 1, 1), res(1, 0, 32767, 1));
    plan_reg(REG_ZONE_MAX_X, 1000);
    plan_reg(REG_ZONE_HALF_WIDTH, 0);
    plan_known(pt(600, 0, 10, 1, 1), res(1, 0, 32767, 1));
    plan_reg(REG_ZONE_HALF_WIDTH, 300);
    plan_reg(REG_ZONE_MAX_Z, 1000);
    plan_reg(REG_ZONE_MIN_Z, 1000);
    plan_known(pt(600, 0, 1000, 1, 1), res(1, 0, 32767, 1));
    plan_reg(REG_ZONE_MIN_Z, 0);
    plan_point(pt(700, 7, 7, 1, 0));
    plan_point(pt(503, -3, 3, 1, 1));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].val);
      else offer_point(plan[i].pt, plan[i].known, plan[i].want);
    end

    // random frames; the first ones pile up behind a long result hold-off
    random_zone(2);
    points_sent = 0;
    hold_off_left = LONG_HOLD;
    while (points_sent < RANDOM_ITEMS) begin
      if (points_sent >= CALM_FROM) begin
        idle_on = 1'b0;
      end else if (hold_off_left == 0) begin
        idle_on = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 5) == 0) random_zone($urandom_range(0, 4));
      end
      if (!paused_once && points_sent >= RANDOM_ITEMS / 2) begin
        await_idle();
        paused_once = 1'b1;
      end
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) offer_point(random_point(k == len - 1), 1'b0, '0);
    end

    await_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pcbod_pkg.sv
hdl/pcbod_front.sv
hdl/pcbod_queue.sv
hdl/pcbod_back.sv
hdl/point_cloud_box_obstacle_detect.sv
verif/point_cloud_box_obstacle_detect_test.sv
